>>> design/rrt_pkg.sv
package rrt_pkg;

   localparam int MAX_NODES     = 1024;
   localparam int NODE_W        = $clog2(MAX_NODES);
   localparam int SIZE_W        = NODE_W + 1;
   localparam int MAX_OBSTACLES = 16;
   localparam int OBS_W         = $clog2(MAX_OBSTACLES);
   localparam int OBS_USE_W     = 5;
   localparam int COORD_W       = 16;
   localparam int STEP_W        = 15;
   localparam int GE_W          = 8;
   localparam int LIMIT_W       = 16;
   localparam int ITER_W        = 17;
   localparam int MOD_CNT_W     = $clog2(ITER_W + 1);
   localparam int STATUS_W      = 3;
   localparam int PARENT_W      = NODE_W + 1;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 16;
   localparam int ACTION_W      = 2;

   localparam int CORDIC_STAGES = 16;
   localparam int CORD_CNT_W    = $clog2(2 * CORDIC_STAGES);
   localparam int CORD_SH_W     = $clog2(CORDIC_STAGES);
   localparam int CW            = 36;
   localparam int CORDIC_FRAC   = 16;
   localparam int SUM_W         = CW - CORDIC_FRAC + 1;
   localparam logic [CW-1:0]        GAIN_CW      = CW'(39797);
   localparam logic signed [CW-1:0] CORDIC_ROUND = CW'(32768);

   localparam int SQ_W  = 2 * COORD_W;
   localparam int THR_W = 2 * STEP_W;

   localparam logic [CSR_IDX_W-1:0] CSR_START_X   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_Y   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GOAL_X    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GOAL_Y    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_GOAL_EVERY = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_ITER_LIMIT = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_OBS_IN_USE = 3'd7;

   localparam logic [COORD_W-1:0] RST_START_X = 16'd256;
   localparam logic [COORD_W-1:0] RST_START_Y = 16'd256;
   localparam logic [COORD_W-1:0] RST_GOAL_X  = 16'd1280;
   localparam logic [COORD_W-1:0] RST_GOAL_Y  = 16'd3328;
   localparam logic [STEP_W-1:0]  RST_STEP    = 15'd51;
   localparam logic [GE_W-1:0]    RST_GOAL_EVERY = 8'd5;
   localparam logic [LIMIT_W-1:0] RST_ITER_LIMIT = 16'd10000;

   localparam logic [STATUS_W-1:0] STATUS_DONE    = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_ADDED   = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_COLLIDE = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_GOAL    = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_LIMIT   = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 3'd5;

   localparam logic [PARENT_W-1:0] PARENT_NONE = '1;

   typedef enum logic [ACTION_W-1:0] {
      ACT_RESTART = 2'd0,
      ACT_LOAD    = 2'd1,
      ACT_SAMPLE  = 2'd2,
      ACT_READ    = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      PM_SCAN,
      PM_OBST,
      PM_GOAL
   } pipe_mode_type;

   typedef enum logic [2:0] {
      RK_RESTART,
      RK_LOAD,
      RK_READ,
      RK_LIMIT,
      RK_FULL,
      RK_COLLIDE,
      RK_COMMIT
   } rsp_kind_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_READ,
      S_ITER,
      S_CHECK,
      S_MOD,
      S_TARGET,
      S_SCAN,
      S_CORD_START,
      S_CORDIC,
      S_STEP,
      S_OBST,
      S_GOAL,
      S_RESULT
   } state_type;

   typedef struct packed {
      logic          capture;
      logic          iter_inc;
      logic          mod_start;
      logic          target_load;
      logic          pipe_start;
      pipe_mode_type pipe_mode;
      logic          cordic_start;
      logic          step_apply;
      logic          rsp_load;
      rsp_kind_type  rsp_kind;
   } rrt_cmd_type;

   typedef struct packed {
      logic limit_hit;
      logic tree_full;
      logic mod_done;
      logic pipe_done;
      logic cordic_done;
      logic obst_hit;
      logic rsp_free;
   } rrt_status_type;

   function automatic logic [COORD_W-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
      logic [SUM_W-COORD_W:0] upper;
      upper = v[SUM_W-1:COORD_W-1];
      if ((&upper) || !(|upper)) begin
         return v[COORD_W-1:0];
      end
      return v[SUM_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
   endfunction

endpackage

>>> design/rrt_ram.sv
module rrt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> design/rrt_dp.sv
module rrt_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write,
   input  logic [rrt_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [rrt_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  logic signed [rrt_pkg::COORD_W-1:0]    req_sample_x,
   input  logic signed [rrt_pkg::COORD_W-1:0]    req_sample_y,
   input  logic [rrt_pkg::OBS_W-1:0]             req_obstacle_slot,
   input  logic signed [rrt_pkg::COORD_W-1:0]    req_obstacle_x,
   input  logic signed [rrt_pkg::COORD_W-1:0]    req_obstacle_y,
   input  logic [rrt_pkg::STEP_W-1:0]            req_obstacle_radius,
   input  logic [rrt_pkg::NODE_W-1:0]            req_node_select,
   input  rrt_pkg::rrt_cmd_type                  cmd,
   output rrt_pkg::rrt_status_type               status,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [rrt_pkg::STATUS_W-1:0]          rsp_status,
   output logic [rrt_pkg::NODE_W-1:0]            rsp_node_index,
   output logic signed [rrt_pkg::COORD_W-1:0]    rsp_node_x,
   output logic signed [rrt_pkg::COORD_W-1:0]    rsp_node_y,
   output logic signed [rrt_pkg::PARENT_W-1:0]   rsp_parent_index
);
   import rrt_pkg::*;

   localparam int RAM_W = 2 * COORD_W + NODE_W;

   logic [COORD_W-1:0]   start_x_ff, start_y_ff, goal_x_ff, goal_y_ff;
   logic [STEP_W-1:0]    step_ff;
   logic [GE_W-1:0]      goal_every_ff;
   logic [LIMIT_W-1:0]   limit_ff;
   logic [OBS_USE_W-1:0] obs_use_ff;

   logic [COORD_W-1:0] sample_x_ff, sample_y_ff, ld_x_ff, ld_y_ff;
   logic [OBS_W-1:0]   ld_slot_ff;
   logic [STEP_W-1:0]  ld_r_ff;
   logic [NODE_W-1:0]  sel_ff;

   logic [COORD_W-1:0] obs_x_ff [MAX_OBSTACLES];
   logic [COORD_W-1:0] obs_y_ff [MAX_OBSTACLES];
   logic [STEP_W-1:0]  obs_r_ff [MAX_OBSTACLES];

   logic [COORD_W-1:0] node0_x_ff, node0_y_ff;
   logic [SIZE_W-1:0]  size_ff;
   logic [ITER_W-1:0]  iter_ff;

   logic                 mod_busy_ff;
   logic [MOD_CNT_W-1:0] mod_cnt_ff;
   logic [ITER_W-1:0]    mod_div_ff;
   logic [GE_W-1:0]      mod_rem_ff, mod_rem_in;
   logic [GE_W:0]        mod_t;

   logic [COORD_W-1:0] tgt_x_ff, tgt_y_ff;

   pipe_mode_type      mode_ff;
   logic [SIZE_W-1:0]  cnt_ff, count_ff, count_in;
   logic               issuing;
   logic               p1_valid_ff, p2_valid_ff;
   logic [NODE_W-1:0]  p1_idx_ff, p2_idx_ff;
   logic [COORD_W-1:0] p2_ax_ff, p2_ay_ff;
   logic [SQ_W-1:0]    p2_sqx_ff, p2_sqy_ff;
   logic [THR_W-1:0]   p2_thr_ff;
   logic [SQ_W:0]      best_d_ff, sum2;
   logic [NODE_W-1:0]  nind_ff;
   logic [COORD_W-1:0] best_x_ff, best_y_ff;
   logic               obst_hit_ff, goal_hit_ff;

   logic [COORD_W-1:0]        a_x, a_y, b_x, b_y;
   logic [STEP_W-1:0]         thr_base;
   logic signed [COORD_W:0]   d1_x, d1_y;
   logic signed [SQ_W+1:0]    sqx_full, sqy_full;
   logic [THR_W-1:0]          thr_full;

   logic                  ram_we;
   logic [NODE_W-1:0]     ram_raddr;
   logic [RAM_W-1:0]      ram_rdata;
   logic [COORD_W-1:0]    ram_x, ram_y;
   logic [NODE_W-1:0]     ram_par;

   logic                    cord_busy_ff, flip_ff, zero_ff;
   logic [CORD_CNT_W-1:0]   cord_cnt_ff;
   logic [CORD_SH_W-1:0]    sh;
   logic signed [CW-1:0]    vx_ff, vy_ff, rx_ff, ry_ff;
   logic signed [CW-1:0]    vx_sh, vy_sh, rx_sh, ry_sh, dx_w, dy_w;
   logic [CORDIC_STAGES-1:0] dirs_ff;
   logic signed [COORD_W:0] cd_x, cd_y;
   logic                    up;

   logic signed [CW-1:0]      rsx, rsy;
   logic signed [SUM_W-2:0]   stx, sty;
   logic signed [SUM_W-1:0]   sum_x, sum_y;
   logic [COORD_W-1:0]        cand_x_ff, cand_y_ff;

   logic                      rsp_valid_ff;
   logic [STATUS_W-1:0]       rsp_status_ff;
   logic [NODE_W-1:0]         rsp_index_ff;
   logic [COORD_W-1:0]        rsp_x_ff, rsp_y_ff;
   logic [PARENT_W-1:0]       rsp_parent_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff    <= RST_START_X;
         start_y_ff    <= RST_START_Y;
         goal_x_ff     <= RST_GOAL_X;
         goal_y_ff     <= RST_GOAL_Y;
         step_ff       <= RST_STEP;
         goal_every_ff <= RST_GOAL_EVERY;
         limit_ff      <= RST_ITER_LIMIT;
         obs_use_ff    <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_START_X:    start_x_ff    <= csr_wdata;
            CSR_START_Y:    start_y_ff    <= csr_wdata;
            CSR_GOAL_X:     goal_x_ff     <= csr_wdata;
            CSR_GOAL_Y:     goal_y_ff     <= csr_wdata;
            CSR_STEP:       step_ff       <= csr_wdata[STEP_W-1:0];
            CSR_GOAL_EVERY: goal_every_ff <= csr_wdata[GE_W-1:0];
            CSR_ITER_LIMIT: limit_ff      <= csr_wdata[LIMIT_W-1:0];
            CSR_OBS_IN_USE: obs_use_ff    <= csr_wdata[OBS_USE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sample_x_ff <= req_sample_x;
         sample_y_ff <= req_sample_y;
         ld_slot_ff  <= req_obstacle_slot;
         ld_x_ff     <= req_obstacle_x;
         ld_y_ff     <= req_obstacle_y;
         ld_r_ff     <= req_obstacle_radius;
         sel_ff      <= req_node_select;
      end
      if (cmd.target_load) begin
         if (goal_every_ff != '0 && mod_rem_ff == '0) begin
            tgt_x_ff <= goal_x_ff;
            tgt_y_ff <= goal_y_ff;
         end else begin
            tgt_x_ff <= sample_x_ff;
            tgt_y_ff <= sample_y_ff;
         end
      end
   end

   // Obstacle table and tree bookkeeping.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_OBSTACLES; i++) begin
            obs_x_ff[i] <= '0;
            obs_y_ff[i] <= '0;
            obs_r_ff[i] <= '0;
         end
         node0_x_ff <= RST_START_X;
         node0_y_ff <= RST_START_Y;
         size_ff    <= SIZE_W'(1);
         iter_ff    <= '0;
      end else begin
         if (cmd.iter_inc && iter_ff != '1) begin
            iter_ff <= iter_ff + 1'b1;
         end
         if (cmd.rsp_load) begin
            case (cmd.rsp_kind)
               RK_RESTART: begin
                  node0_x_ff <= start_x_ff;
                  node0_y_ff <= start_y_ff;
                  size_ff    <= SIZE_W'(1);
                  iter_ff    <= '0;
               end
               RK_LOAD: begin
                  obs_x_ff[ld_slot_ff] <= ld_x_ff;
                  obs_y_ff[ld_slot_ff] <= ld_y_ff;
                  obs_r_ff[ld_slot_ff] <= ld_r_ff;
               end
               RK_COMMIT: size_ff <= size_ff + 1'b1;
               default: ;
            endcase
         end
      end
   end

   // Remainder of the iteration count by goal_every, one bit a cycle.
   assign mod_t      = {mod_rem_ff, mod_div_ff[ITER_W-1]};
   assign mod_rem_in = (mod_t >= {1'b0, goal_every_ff}) ?
                       GE_W'(mod_t - {1'b0, goal_every_ff}) : mod_t[GE_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_busy_ff <= 1'b0;
      end else if (cmd.mod_start) begin
         mod_busy_ff <= 1'b1;
      end else if (mod_busy_ff && mod_cnt_ff == MOD_CNT_W'(1)) begin
         mod_busy_ff <= 1'b0;
      end
      if (cmd.mod_start) begin
         mod_cnt_ff <= MOD_CNT_W'(ITER_W);
         mod_div_ff <= iter_ff;
         mod_rem_ff <= '0;
      end else if (mod_busy_ff) begin
         mod_cnt_ff <= mod_cnt_ff - 1'b1;
         mod_div_ff <= {mod_div_ff[ITER_W-2:0], 1'b0};
         mod_rem_ff <= mod_rem_in;
      end
   end

   // Distance pipeline: issue, operand fetch and squares, sum and compare.
   assign issuing = cnt_ff < count_ff;

   always_comb begin
      unique case (cmd.pipe_mode)
         PM_SCAN: count_in = size_ff;
         PM_OBST: count_in = (obs_use_ff > OBS_USE_W'(MAX_OBSTACLES)) ?
                             SIZE_W'(MAX_OBSTACLES) : SIZE_W'(obs_use_ff);
         default: count_in = SIZE_W'(1);
      endcase
   end

   assign ram_raddr = issuing ? cnt_ff[NODE_W-1:0] : sel_ff;
   assign ram_x     = ram_rdata[RAM_W-1 -: COORD_W];
   assign ram_y     = ram_rdata[NODE_W +: COORD_W];
   assign ram_par   = ram_rdata[NODE_W-1:0];

   always_comb begin
      unique case (mode_ff)
         PM_SCAN: begin
            a_x      = (p1_idx_ff == '0) ? node0_x_ff : ram_x;
            a_y      = (p1_idx_ff == '0) ? node0_y_ff : ram_y;
            b_x      = tgt_x_ff;
            b_y      = tgt_y_ff;
            thr_base = '0;
         end
         PM_OBST: begin
            a_x      = obs_x_ff[p1_idx_ff[OBS_W-1:0]];
            a_y      = obs_y_ff[p1_idx_ff[OBS_W-1:0]];
            b_x      = cand_x_ff;
            b_y      = cand_y_ff;
            thr_base = obs_r_ff[p1_idx_ff[OBS_W-1:0]];
         end
         default: begin
            a_x      = goal_x_ff;
            a_y      = goal_y_ff;
            b_x      = cand_x_ff;
            b_y      = cand_y_ff;
            thr_base = step_ff;
         end
      endcase
      d1_x     = $signed({a_x[COORD_W-1], a_x}) - $signed({b_x[COORD_W-1], b_x});
      d1_y     = $signed({a_y[COORD_W-1], a_y}) - $signed({b_y[COORD_W-1], b_y});
      sqx_full = d1_x * d1_x;
      sqy_full = d1_y * d1_y;
      thr_full = thr_base * thr_base;
   end

   assign sum2 = {1'b0, p2_sqx_ff} + {1'b0, p2_sqy_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= '0;
         count_ff    <= '0;
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         mode_ff     <= PM_SCAN;
         obst_hit_ff <= 1'b0;
         goal_hit_ff <= 1'b0;
      end else begin
         p1_valid_ff <= issuing;
         p2_valid_ff <= p1_valid_ff;
         if (cmd.pipe_start) begin
            cnt_ff      <= '0;
            count_ff    <= count_in;
            mode_ff     <= cmd.pipe_mode;
            obst_hit_ff <= 1'b0;
         end else if (issuing) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
         if (p2_valid_ff) begin
            unique case (mode_ff)
               PM_SCAN: ;
               PM_OBST: begin
                  if (sum2 <= (SQ_W + 1)'(p2_thr_ff)) begin
                     obst_hit_ff <= 1'b1;
                  end
               end
               default: goal_hit_ff <= sum2 <= (SQ_W + 1)'(p2_thr_ff);
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      p1_idx_ff <= cnt_ff[NODE_W-1:0];
      p2_idx_ff <= p1_idx_ff;
      p2_ax_ff  <= a_x;
      p2_ay_ff  <= a_y;
      p2_sqx_ff <= sqx_full[SQ_W-1:0];
      p2_sqy_ff <= sqy_full[SQ_W-1:0];
      p2_thr_ff <= thr_full;
      if (p2_valid_ff && mode_ff == PM_SCAN && (p2_idx_ff == '0 || sum2 < best_d_ff)) begin
         best_d_ff <= sum2;
         nind_ff   <= p2_idx_ff;
         best_x_ff <= p2_ax_ff;
         best_y_ff <= p2_ay_ff;
      end
   end

   // CORDIC: sixteen vectoring stages, then sixteen rotation stages.
   assign sh    = cord_cnt_ff[CORD_SH_W-1:0];
   assign vx_sh = vx_ff >>> sh;
   assign vy_sh = vy_ff >>> sh;
   assign rx_sh = rx_ff >>> sh;
   assign ry_sh = ry_ff >>> sh;
   assign up    = cord_cnt_ff[CORD_CNT_W-1] ? dirs_ff[sh] : !vy_ff[CW-1];
   assign cd_x  = $signed({tgt_x_ff[COORD_W-1], tgt_x_ff}) -
                  $signed({best_x_ff[COORD_W-1], best_x_ff});
   assign cd_y  = $signed({tgt_y_ff[COORD_W-1], tgt_y_ff}) -
                  $signed({best_y_ff[COORD_W-1], best_y_ff});
   assign dx_w  = CW'(cd_x) <<< CORDIC_FRAC;
   assign dy_w  = CW'(cd_y) <<< CORDIC_FRAC;

   always_ff @(posedge clock) begin
      if (reset) begin
         cord_busy_ff <= 1'b0;
      end else if (cmd.cordic_start) begin
         cord_busy_ff <= 1'b1;
      end else if (cord_busy_ff && cord_cnt_ff == '1) begin
         cord_busy_ff <= 1'b0;
      end
      if (cmd.cordic_start) begin
         cord_cnt_ff <= '0;
         zero_ff     <= (cd_x == '0) && (cd_y == '0);
         flip_ff     <= cd_x[COORD_W];
         vx_ff       <= cd_x[COORD_W] ? -dx_w : dx_w;
         vy_ff       <= cd_x[COORD_W] ? -dy_w : dy_w;
         rx_ff       <= $signed({{(CW - STEP_W){1'b0}}, step_ff} * GAIN_CW);
         ry_ff       <= '0;
      end else if (cord_busy_ff) begin
         cord_cnt_ff <= cord_cnt_ff + 1'b1;
         if (!cord_cnt_ff[CORD_CNT_W-1]) begin
            dirs_ff[sh] <= up;
            vx_ff       <= up ? vx_ff + vy_sh : vx_ff - vy_sh;
            vy_ff       <= up ? vy_ff - vx_sh : vy_ff + vx_sh;
         end else begin
            rx_ff <= up ? rx_ff - ry_sh : rx_ff + ry_sh;
            ry_ff <= up ? ry_ff + rx_sh : ry_ff - rx_sh;
         end
      end
   end

   always_comb begin
      rsx = (rx_ff + CORDIC_ROUND) >>> CORDIC_FRAC;
      rsy = (ry_ff + CORDIC_ROUND) >>> CORDIC_FRAC;
      if (zero_ff) begin
         stx = (SUM_W - 1)'(step_ff);
         sty = '0;
      end else if (flip_ff) begin
         stx = -rsx[SUM_W-2:0];
         sty = -rsy[SUM_W-2:0];
      end else begin
         stx = rsx[SUM_W-2:0];
         sty = rsy[SUM_W-2:0];
      end
      sum_x = SUM_W'($signed(best_x_ff)) + SUM_W'(stx);
      sum_y = SUM_W'($signed(best_y_ff)) + SUM_W'(sty);
   end

   always_ff @(posedge clock) begin
      if (cmd.step_apply) begin
         cand_x_ff <= sat_coord(sum_x);
         cand_y_ff <= sat_coord(sum_y);
      end
   end

   assign ram_we = cmd.rsp_load && cmd.rsp_kind == RK_COMMIT;

   rrt_ram #(
      .WIDTH(RAM_W),
      .DEPTH(MAX_NODES)
   ) u_tree (
      .clock (clock),
      .we    (ram_we),
      .waddr (size_ff[NODE_W-1:0]),
      .wdata ({cand_x_ff, cand_y_ff, nind_ff}),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Output word register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= STATUS_DONE;
         rsp_index_ff  <= '0;
         rsp_x_ff      <= '0;
         rsp_y_ff      <= '0;
         rsp_parent_ff <= '0;
         case (cmd.rsp_kind)
            RK_RESTART: begin
               rsp_x_ff      <= start_x_ff;
               rsp_y_ff      <= start_y_ff;
               rsp_parent_ff <= PARENT_NONE;
            end
            RK_READ: begin
               rsp_index_ff <= sel_ff;
               if (sel_ff == '0) begin
                  rsp_x_ff      <= node0_x_ff;
                  rsp_y_ff      <= node0_y_ff;
                  rsp_parent_ff <= PARENT_NONE;
               end else if ({1'b0, sel_ff} < size_ff) begin
                  rsp_x_ff      <= ram_x;
                  rsp_y_ff      <= ram_y;
                  rsp_parent_ff <= {1'b0, ram_par};
               end
            end
            RK_LIMIT: rsp_status_ff <= STATUS_LIMIT;
            RK_FULL:  rsp_status_ff <= STATUS_FULL;
            RK_COLLIDE, RK_COMMIT: begin
               if (cmd.rsp_kind == RK_COLLIDE) begin
                  rsp_status_ff <= STATUS_COLLIDE;
               end else begin
                  rsp_status_ff <= goal_hit_ff ? STATUS_GOAL : STATUS_ADDED;
               end
               rsp_index_ff  <= size_ff[NODE_W-1:0];
               rsp_x_ff      <= cand_x_ff;
               rsp_y_ff      <= cand_y_ff;
               rsp_parent_ff <= {1'b0, nind_ff};
            end
            default: ;
         endcase
      end
   end

   assign status.limit_hit   = iter_ff > {1'b0, limit_ff};
   assign status.tree_full   = size_ff >= SIZE_W'(MAX_NODES);
   assign status.mod_done    = !mod_busy_ff;
   assign status.pipe_done   = !issuing && !p1_valid_ff && !p2_valid_ff;
   assign status.cordic_done = !cord_busy_ff;
   assign status.obst_hit    = obst_hit_ff;
   assign status.rsp_free    = !rsp_valid_ff || rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_node_index   = rsp_index_ff;
   assign rsp_node_x       = rsp_x_ff;
   assign rsp_node_y       = rsp_y_ff;
   assign rsp_parent_index = rsp_parent_ff;

endmodule

>>> design/rrt_ctrl.sv
module rrt_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic [rrt_pkg::ACTION_W-1:0]   req_action,
   output logic                           req_ready,
   input  rrt_pkg::rrt_status_type        status,
   output rrt_pkg::rrt_cmd_type           cmd
);
   import rrt_pkg::*;

   state_type    state_ff, state_in;
   rsp_kind_type kind_ff, kind_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         kind_ff  <= RK_LOAD;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (action_type'(req_action))
                  ACT_RESTART: begin
                     state_in = S_RESULT;
                     kind_in  = RK_RESTART;
                  end
                  ACT_LOAD: begin
                     state_in = S_RESULT;
                     kind_in  = RK_LOAD;
                  end
                  ACT_READ: begin
                     state_in = S_READ;
                     kind_in  = RK_READ;
                  end
                  default: state_in = S_ITER;
               endcase
            end
         end
         S_READ: state_in = S_RESULT;
         S_ITER: state_in = S_CHECK;
         S_CHECK: begin
            if (status.limit_hit) begin
               state_in = S_RESULT;
               kind_in  = RK_LIMIT;
            end else if (status.tree_full) begin
               state_in = S_RESULT;
               kind_in  = RK_FULL;
            end else begin
               state_in = S_MOD;
            end
         end
         S_MOD: if (status.mod_done) state_in = S_TARGET;
         S_TARGET: state_in = S_SCAN;
         S_SCAN: if (status.pipe_done) state_in = S_CORD_START;
         S_CORD_START: state_in = S_CORDIC;
         S_CORDIC: if (status.cordic_done) state_in = S_STEP;
         S_STEP: state_in = S_OBST;
         S_OBST: begin
            if (status.pipe_done) begin
               if (status.obst_hit) begin
                  state_in = S_RESULT;
                  kind_in  = RK_COLLIDE;
               end else begin
                  state_in = S_GOAL;
               end
            end
         end
         S_GOAL: begin
            if (status.pipe_done) begin
               state_in = S_RESULT;
               kind_in  = RK_COMMIT;
            end
         end
         S_RESULT: if (status.rsp_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd           = '0;
      cmd.pipe_mode = PM_SCAN;
      cmd.rsp_kind  = kind_ff;
      req_ready     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         S_ITER: cmd.iter_inc = 1'b1;
         S_CHECK: cmd.mod_start = !status.limit_hit && !status.tree_full;
         S_TARGET: begin
            cmd.target_load = 1'b1;
            cmd.pipe_start  = 1'b1;
            cmd.pipe_mode   = PM_SCAN;
         end
         S_CORD_START: cmd.cordic_start = 1'b1;
         S_STEP: begin
            cmd.step_apply = 1'b1;
            cmd.pipe_start = 1'b1;
            cmd.pipe_mode  = PM_OBST;
         end
         S_OBST: begin
            cmd.pipe_start = status.pipe_done && !status.obst_hit;
            cmd.pipe_mode  = PM_GOAL;
         end
         S_RESULT: cmd.rsp_load = status.rsp_free;
         default: ;
      endcase
   end

endmodule

>>> design/rrt_tree_extender_core.sv
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_ready  action, sample, obstacle, node_select
// rsp       out        rsp_valid/rsp_ready  status, node_index, node_x, node_y, parent
// csr       in         csr_write            csr_index, csr_wdata
//
// One word is in work at a time. Restart and obstacle load go from idle straight
// to the result state, a node read passes a read state first, and a sample's time
// is set by the one-node-a-cycle nearest search through the tree RAM read port,
// the remainder unit and the CORDIC.
// Reset is synchronous and leaves the tree holding only the start node.
// A new word is taken while the last result still waits in the output register.
module rrt_tree_extender_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write,
   input  logic [rrt_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [rrt_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [rrt_pkg::ACTION_W-1:0]          req_action,
   input  logic signed [rrt_pkg::COORD_W-1:0]    req_sample_x,
   input  logic signed [rrt_pkg::COORD_W-1:0]    req_sample_y,
   input  logic [rrt_pkg::OBS_W-1:0]             req_obstacle_slot,
   input  logic signed [rrt_pkg::COORD_W-1:0]    req_obstacle_x,
   input  logic signed [rrt_pkg::COORD_W-1:0]    req_obstacle_y,
   input  logic [rrt_pkg::STEP_W-1:0]            req_obstacle_radius,
   input  logic [rrt_pkg::NODE_W-1:0]            req_node_select,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [rrt_pkg::STATUS_W-1:0]          rsp_status,
   output logic [rrt_pkg::NODE_W-1:0]            rsp_node_index,
   output logic signed [rrt_pkg::COORD_W-1:0]    rsp_node_x,
   output logic signed [rrt_pkg::COORD_W-1:0]    rsp_node_y,
   output logic signed [rrt_pkg::PARENT_W-1:0]   rsp_parent_index
);
   import rrt_pkg::*;

   rrt_cmd_type    cmd;
   rrt_status_type status;

   rrt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_ready  (req_ready),
      .status     (status),
      .cmd        (cmd)
   );

   rrt_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_sample_x        (req_sample_x),
      .req_sample_y        (req_sample_y),
      .req_obstacle_slot   (req_obstacle_slot),
      .req_obstacle_x      (req_obstacle_x),
      .req_obstacle_y      (req_obstacle_y),
      .req_obstacle_radius (req_obstacle_radius),
      .req_node_select     (req_node_select),
      .cmd                 (cmd),
      .status              (status),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_node_index      (rsp_node_index),
      .rsp_node_x          (rsp_node_x),
      .rsp_node_y          (rsp_node_y),
      .rsp_parent_index    (rsp_parent_index)
   );

endmodule
